/* src/assert_macros.svh */
// Assertion macros for the checker file of this block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("checker assertion failed");

// Property checked on every rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("checker assertion failed");

`endif

/* src/dngd_pkg.sv */
// Package for the day number to Gregorian date converter: field widths,
// calendar span constants and the month start table. Depends on nothing.
`timescale 1ns / 1ps

package dngd_pkg;

   localparam int DAY_NUMBER_W = 31;
   localparam int YEAR_W       = 23;
   localparam int MONTH_W      = 4;
   localparam int DOM_W        = 5;
   localparam int REM_W        = 18;
   localparam int DOY_W        = 9;

   typedef logic [DAY_NUMBER_W-1:0] day_number_type;
   typedef logic [YEAR_W-1:0]       year_type;
   typedef logic [MONTH_W-1:0]      month_type;
   typedef logic [DOM_W-1:0]        dom_type;
   typedef logic [REM_W-1:0]        rem_type;

   // Calendar spans in days.
   localparam logic [REM_W:0]   SPAN_400Y         = 19'd146097;
   localparam rem_type          SPAN_FIRST_100Y   = 18'd36525;
   localparam rem_type          SPAN_100Y         = 18'd36524;
   localparam rem_type          SPAN_4Y           = 18'd1461;
   localparam rem_type          SPAN_4Y_COMMON    = 18'd1460;
   localparam rem_type          COMMON_YEAR_DAYS  = 18'd365;
   localparam rem_type          LEAP_YEAR_DAYS    = 18'd366;
   localparam rem_type          LEAP_DAY_INDEX    = 18'd59;
   localparam month_type        LAST_MONTH        = 4'd11;

   // First day of each month, counted from 1 January, in a leap year.
   function automatic logic [DOY_W-1:0] month_start(input month_type m);
      logic [DOY_W-1:0] s;
      case (m)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd60;
         4'd3:    s = 9'd91;
         4'd4:    s = 9'd121;
         4'd5:    s = 9'd152;
         4'd6:    s = 9'd182;
         4'd7:    s = 9'd213;
         4'd8:    s = 9'd244;
         4'd9:    s = 9'd274;
         4'd10:   s = 9'd305;
         4'd11:   s = 9'd335;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   // Leap test on a year held as 400*q + 100*cent + 4*four + ones, with
   // four below 25 and ones below 4: only a century year outside the first
   // century of a 400-year span is skipped.
   function automatic logic is_leap(input logic [1:0] cent, input logic [4:0] four,
                                    input logic [1:0] ones);
      return (ones == 2'd0) && ((four != 5'd0) || (cent == 2'd0));
   endfunction

endpackage

/* src/day_number_to_gregorian_date.sv */
// Day number to Gregorian date converter, top level. Depends on dngd_pkg.
// The 31-step bit-serial division by the 400-year span dominates the latency;
// the rest is serial peeling. One item is in flight at a time: the next item
// is taken once the result sits in the output register, even while that
// result is stalled. Reset (synchronous, active high) returns to idle and
// empties the output.
`timescale 1ns / 1ps

module day_number_to_gregorian_date
   import dngd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  day_number_type req_day_number,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output year_type       rsp_year,
   output month_type      rsp_month,
   output dom_type        rsp_day_of_month
);

   // Sequencer states. Each step of the calendar peel has a state of its own;
   // the two divisions run one quotient bit per cycle.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;   // restoring division by 146097
   localparam logic [3:0] ST_CENT0 = 4'd2;   // first (leap) century of the span
   localparam logic [3:0] ST_CENTN = 4'd3;   // further 36524-day centuries
   localparam logic [3:0] ST_SKIP  = 4'd4;   // leap-free first four years
   localparam logic [3:0] ST_DIV4  = 4'd5;   // division by 1461, five bits
   localparam logic [3:0] ST_YEARS = 4'd6;   // single years, at most three
   localparam logic [3:0] ST_ADJ   = 4'd7;   // skip 29 February in common years
   localparam logic [3:0] ST_YRADD = 4'd8;   // add the sub-400 year offset
   localparam logic [3:0] ST_MONTH = 4'd9;   // search down the month table
   localparam logic [3:0] ST_FIN   = 4'd10;  // hand the result to the output

   logic [3:0]     state_ff, state_in;
   day_number_type div_ff, div_in;      // dividend bits out, quotient bits in
   rem_type        rem_ff, rem_in;      // running remainder, later day of year
   logic [4:0]     cnt_ff, cnt_in;
   logic [1:0]     cent_ff, cent_in;
   logic [4:0]     four_ff, four_in;
   logic [1:0]     ones_ff, ones_in;
   year_type       yr_ff, yr_in;
   month_type      mon_ff, mon_in;

   logic           rsp_valid_ff, rsp_valid_in;
   year_type       rsp_year_ff, rsp_year_in;
   month_type      rsp_month_ff, rsp_month_in;
   dom_type        rsp_dom_ff, rsp_dom_in;

   logic [REM_W:0]   partial;
   logic [REM_W:0]   partial_diff;
   logic             partial_ge;
   rem_type          div4_divisor;
   logic             leap;
   rem_type          year_len;
   rem_type          adj_rem;
   logic [13:0]      q400;
   logic [DOY_W-1:0] year_low;
   logic [DOY_W-1:0] mon_start;
   logic             out_free;

   // One bit of the 400-year division: shift in the next dividend bit and
   // subtract the span when it fits.
   assign partial      = {rem_ff, div_ff[DAY_NUMBER_W-1]};
   assign partial_diff = partial - SPAN_400Y;
   assign partial_ge   = (partial >= SPAN_400Y);

   // The 4-year division tests 1461 shifted left by the current quotient bit.
   assign div4_divisor = rem_type'(SPAN_4Y << cnt_ff[2:0]);

   assign leap      = is_leap(cent_ff, four_ff, ones_ff);
   assign year_len  = leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
   assign q400      = div_ff[13:0];
   assign mon_start = month_start(mon_ff);

   // Year offset inside the 400-year span: 100 * cent + 4 * four + ones.
   assign year_low = DOY_W'({cent_ff, 6'b0}) + DOY_W'({cent_ff, 5'b0})
                   + DOY_W'({cent_ff, 2'b0}) + DOY_W'({four_ff, 2'b0})
                   + DOY_W'(ones_ff);

   // Common years map onto the leap-year table by stepping over 29 February.
   always_comb begin
      adj_rem = rem_ff;
      if (!leap && (rem_ff >= LEAP_DAY_INDEX)) begin
         adj_rem = rem_ff + 18'd1;
      end
      if (adj_rem > COMMON_YEAR_DAYS) begin
         adj_rem = COMMON_YEAR_DAYS;
      end
   end

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      cent_in      = cent_ff;
      four_in      = four_ff;
      ones_in      = ones_ff;
      yr_in        = yr_ff;
      mon_in       = mon_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_month_in = rsp_month_ff;
      rsp_dom_in   = rsp_dom_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               div_in   = req_day_number;
               rem_in   = '0;
               cnt_in   = 5'(DAY_NUMBER_W - 1);
               cent_in  = 2'd0;
               four_in  = 5'd0;
               ones_in  = 2'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_in = {div_ff[DAY_NUMBER_W-2:0], partial_ge};
            rem_in = partial_ge ? partial_diff[REM_W-1:0] : partial[REM_W-1:0];
            if (cnt_ff == 5'd0) begin
               state_in = ST_CENT0;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_CENT0: begin
            if (rem_ff >= SPAN_FIRST_100Y) begin
               rem_in   = rem_ff - SPAN_FIRST_100Y;
               cent_in  = 2'd1;
               state_in = ST_CENTN;
            end else begin
               state_in = ST_SKIP;
            end
         end
         ST_CENTN: begin
            if ((rem_ff >= SPAN_100Y) && (cent_ff != 2'd3)) begin
               rem_in  = rem_ff - SPAN_100Y;
               cent_in = cent_ff + 2'd1;
            end else begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // A century that is not a multiple of 400 opens with four
            // common years, one day short of a regular 4-year span.
            if (!leap && (rem_ff >= SPAN_4Y_COMMON)) begin
               rem_in  = rem_ff - SPAN_4Y_COMMON;
               four_in = 5'd1;
            end
            cnt_in   = 5'd4;
            state_in = ST_DIV4;
         end
         ST_DIV4: begin
            if (rem_ff >= div4_divisor) begin
               rem_in  = rem_ff - div4_divisor;
               four_in = four_ff + (5'd1 << cnt_ff[2:0]);
            end
            if (cnt_ff == 5'd0) begin
               state_in = ST_YEARS;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_YEARS: begin
            if ((rem_ff >= year_len) && (ones_ff != 2'd3)) begin
               rem_in  = rem_ff - year_len;
               ones_in = ones_ff + 2'd1;
            end else begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            rem_in   = adj_rem;
            // 400 * q as three shifted copies of the quotient.
            yr_in    = {1'b0, q400, 8'b0} + {2'b0, q400, 7'b0} + {5'b0, q400, 4'b0};
            mon_in   = LAST_MONTH;
            state_in = ST_YRADD;
         end
         ST_YRADD: begin
            yr_in    = yr_ff + {{(YEAR_W - DOY_W){1'b0}}, year_low};
            state_in = ST_MONTH;
         end
         ST_MONTH: begin
            if ((mon_ff != 4'd0) && (rem_ff < {{(REM_W - DOY_W){1'b0}}, mon_start})) begin
               mon_in = mon_ff - 4'd1;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_year_in  = yr_ff;
               rsp_month_in = mon_ff;
               rsp_dom_in   = dom_type'(rem_ff[DOY_W-1:0] - mon_start + 9'd1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      cent_ff      <= cent_in;
      four_ff      <= four_in;
      ones_ff      <= ones_in;
      yr_ff        <= yr_in;
      mon_ff       <= mon_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_month_ff <= rsp_month_in;
      rsp_dom_ff   <= rsp_dom_in;
   end

   // An item is taken only in idle; reset also holds the input side off.
   assign req_stall        = reset || (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_dom_ff;

endmodule

/* src/dngd_checker.sv */
// Port-level checker for the day number to Gregorian date converter and its
// bind. Depends on dngd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dngd_checker
   import dngd_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_stall,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input year_type       rsp_year,
   input month_type      rsp_month,
   input dom_type        rsp_day_of_month
);

   logic [YEAR_W+MONTH_W+DOM_W-1:0] rsp_date;
   logic                            rsp_in_range;

   assign rsp_date     = {rsp_year, rsp_month, rsp_day_of_month};
   assign rsp_in_range = (rsp_month <= LAST_MONTH) && (rsp_day_of_month != 5'd0);

   `CHK_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_date))
   `CHK_ASSERT(a_busy_after_take, clock, reset, req_valid && !req_stall |=> req_stall)
   `CHK_ASSERT(a_date_range, clock, reset, rsp_valid |-> rsp_in_range)
   `CHK_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid)

endmodule

bind day_number_to_gregorian_date dngd_checker u_dngd_checker (.*);
